// File: design/mtep_pkg.sv
`timescale 1ns / 1ps

package mtep_pkg;

	// longest delta-time or length quantity, in bytes
	localparam int VLQ_MAX_BYTES = 4;
	localparam int VLQ_W         = 28;
	localparam int VLQ_CNT_W     = 3;

	typedef logic [3:0]       phase_t;
	typedef logic [2:0]       role_t;
	typedef logic [2:0]       err_t;
	typedef logic [VLQ_W-1:0] vlq_t;

	localparam phase_t PH_DELTA      = 4'd0;
	localparam phase_t PH_STATUS     = 4'd1;
	localparam phase_t PH_META_TYPE  = 4'd2;
	localparam phase_t PH_META_LEN   = 4'd3;
	localparam phase_t PH_META_DATA  = 4'd4;
	localparam phase_t PH_SYSEX_LEN  = 4'd5;
	localparam phase_t PH_SYSEX_DATA = 4'd6;
	localparam phase_t PH_CHAN_DATA  = 4'd7;
	localparam phase_t PH_FAILED     = 4'd8;

	localparam role_t ROLE_DELTA     = 3'd0;
	localparam role_t ROLE_STATUS    = 3'd1;
	localparam role_t ROLE_META_TYPE = 3'd2;
	localparam role_t ROLE_LENGTH    = 3'd3;
	localparam role_t ROLE_TEXT      = 3'd4;
	localparam role_t ROLE_SKIPPED   = 3'd5;
	localparam role_t ROLE_CHAN_DATA = 3'd6;
	localparam role_t ROLE_ERROR     = 3'd7;

	localparam err_t ERR_NONE       = 3'd0;
	localparam err_t ERR_VLQ_LONG   = 3'd1;
	localparam err_t ERR_NO_RUNNING = 3'd2;
	localparam err_t ERR_BAD_STATUS = 3'd3;
	localparam err_t ERR_TRUNCATED  = 3'd4;

	localparam logic [7:0] ST_META      = 8'hFF;
	localparam logic [7:0] ST_SYSEX     = 8'hF0;
	localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
	localparam logic [7:0] ST_NONE      = 8'h00;
	localparam logic [7:0] META_TEXT_LO = 8'h01;
	localparam logic [7:0] META_TEXT_HI = 8'h09;
	// channel messages 0xC0..0xDF carry one data byte
	localparam logic [2:0] ST_ONE_DATA_TOP = 3'b110;

	typedef struct packed {
		role_t       byte_role;
		logic [7:0]  meta_kind;
		logic        text_valid;
		logic        text_last;
		err_t        error_code;
		logic        track_done;
		logic        track_ok;
		logic        track_chan_seen;
		logic [9:0]  track_echo;
	} result_t;

endpackage

// File: design/midi_track_event_parser.sv
`timescale 1ns / 1ps

// channel   valid          stall          word
// byte      byte_valid     byte_stall     data_byte, chunk_last, track_number
// result    result_valid   result_stall   byte_role .. track_echo
//
// one byte per cycle while byte_stall is low: each byte is parsed in the cycle it is
// taken and its result is registered
// a skid register holds one extra result, so byte_stall only rises after the
// result side has stalled with both registers full
// reset returns the parser to the start of a chunk and empties both registers
// the byte marked chunk_last also returns the parser to the start of a chunk
module midi_track_event_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  logic [7:0]           data_byte,
	input  logic                 chunk_last,
	input  logic [9:0]           track_number,
	output logic                 result_valid,
	input  logic                 result_stall,
	output mtep_pkg::role_t      byte_role,
	output logic [7:0]           meta_kind,
	output logic                 text_valid,
	output logic                 text_last,
	output mtep_pkg::err_t       error_code,
	output logic                 track_done,
	output logic                 track_ok,
	output logic                 track_chan_seen,
	output logic [9:0]           track_echo
);
	import mtep_pkg::*;

	phase_t               phase_q, phase_n;
	vlq_t                 vlq_value_q, vlq_value_n;
	logic [VLQ_CNT_W-1:0] vlq_bytes_q, vlq_bytes_n;
	logic [7:0]           running_stat_q, running_stat_n;
	logic [7:0]           meta_type_q, meta_type_n;
	vlq_t                 remaining_q, remaining_n;
	logic                 saw_channel_q, saw_channel_n;
	err_t                 sticky_err_q, sticky_err_n;

	logic    accept;
	logic    out_valid_q, skid_valid_q;
	logic    out_load;
	result_t out_q, skid_q, res_n;

	vlq_t                 vlq_shift;
	vlq_t                 remaining_dec;
	logic                 vlq_more;
	logic                 vlq_too_long;
	logic [VLQ_CNT_W:0]   vlq_count_inc;
	err_t                 fail;
	err_t                 code;
	logic                 is_text_type;

	assign accept     = byte_valid && !skid_valid_q;
	assign byte_stall = skid_valid_q;
	assign out_load   = !out_valid_q || !result_stall;

	assign vlq_shift     = {vlq_value_q[VLQ_W-8:0], data_byte[6:0]};
	assign vlq_more      = data_byte[7];
	assign vlq_count_inc = {1'b0, vlq_bytes_q} + {{VLQ_CNT_W{1'b0}}, 1'b1};
	assign vlq_too_long  = vlq_more && (vlq_count_inc >= (VLQ_CNT_W+1)'(VLQ_MAX_BYTES));
	assign remaining_dec = remaining_q - {{(VLQ_W-1){1'b0}}, 1'b1};
	assign is_text_type  = (meta_type_q >= META_TEXT_LO) && (meta_type_q <= META_TEXT_HI);

	always_comb begin
		phase_n        = phase_q;
		vlq_value_n    = vlq_value_q;
		vlq_bytes_n    = vlq_bytes_q;
		running_stat_n = running_stat_q;
		meta_type_n    = meta_type_q;
		remaining_n    = remaining_q;
		saw_channel_n  = saw_channel_q;
		sticky_err_n   = sticky_err_q;
		fail           = ERR_NONE;
		code           = ERR_NONE;

		res_n                   = '0;
		res_n.byte_role         = ROLE_ERROR;
		res_n.track_echo        = track_number;

		if (sticky_err_q == ERR_NONE) begin
			unique case (phase_q)
				PH_DELTA, PH_META_LEN, PH_SYSEX_LEN: begin
					res_n.byte_role = (phase_q == PH_DELTA) ? ROLE_DELTA : ROLE_LENGTH;
					vlq_value_n     = vlq_shift;
					if (vlq_too_long) begin
						fail = ERR_VLQ_LONG;
					end else if (vlq_more) begin
						vlq_bytes_n = vlq_count_inc[VLQ_CNT_W-1:0];
					end else begin
						vlq_bytes_n = '0;
						vlq_value_n = '0;
						if (phase_q == PH_DELTA) begin
							phase_n = PH_STATUS;
						end else begin
							remaining_n = vlq_shift;
							if (vlq_shift == '0)
								phase_n = PH_DELTA;
							else if (phase_q == PH_META_LEN)
								phase_n = PH_META_DATA;
							else
								phase_n = PH_SYSEX_DATA;
						end
					end
				end
				PH_STATUS: begin
					res_n.byte_role = ROLE_STATUS;
					if (!data_byte[7]) begin
						// data byte reuses the running status
						if (running_stat_q == ST_NONE) begin
							fail = ERR_NO_RUNNING;
						end else begin
							res_n.byte_role = ROLE_CHAN_DATA;
							saw_channel_n   = 1'b1;
							if (running_stat_q[7:5] == ST_ONE_DATA_TOP) begin
								remaining_n = '0;
								phase_n     = PH_DELTA;
							end else begin
								remaining_n = VLQ_W'(1);
								phase_n     = PH_CHAN_DATA;
							end
						end
					end else if (data_byte == ST_META) begin
						running_stat_n = ST_NONE;
						phase_n        = PH_META_TYPE;
					end else if (data_byte == ST_SYSEX || data_byte == ST_SYSEX_ESC) begin
						running_stat_n = ST_NONE;
						phase_n        = PH_SYSEX_LEN;
					end else if (data_byte[7:4] == 4'hF) begin
						fail = ERR_BAD_STATUS;
					end else begin
						running_stat_n = data_byte;
						saw_channel_n  = 1'b1;
						remaining_n    = (data_byte[7:5] == ST_ONE_DATA_TOP) ?
							VLQ_W'(1) : VLQ_W'(2);
						phase_n        = PH_CHAN_DATA;
					end
				end
				PH_META_TYPE: begin
					res_n.byte_role = ROLE_META_TYPE;
					meta_type_n     = data_byte;
					phase_n         = PH_META_LEN;
				end
				PH_META_DATA, PH_SYSEX_DATA, PH_CHAN_DATA: begin
					if (phase_q == PH_CHAN_DATA) begin
						res_n.byte_role = ROLE_CHAN_DATA;
					end else if (phase_q == PH_META_DATA && is_text_type) begin
						res_n.byte_role = ROLE_TEXT;
						res_n.text_valid = 1'b1;
						res_n.text_last  = (remaining_q == VLQ_W'(1));
					end else begin
						res_n.byte_role = ROLE_SKIPPED;
					end
					remaining_n = remaining_dec;
					if (remaining_dec == '0)
						phase_n = PH_DELTA;
				end
				default: begin
					fail = ERR_BAD_STATUS;
				end
			endcase
			if (fail != ERR_NONE) begin
				sticky_err_n    = fail;
				res_n.byte_role = ROLE_ERROR;
				phase_n         = PH_FAILED;
			end
		end

		code = sticky_err_n;
		if (chunk_last) begin
			// chunk ended inside an event
			if (code == ERR_NONE && (phase_n != PH_DELTA || vlq_bytes_n != '0))
				code = ERR_TRUNCATED;
			res_n.track_done      = 1'b1;
			res_n.track_ok        = (code == ERR_NONE);
			res_n.track_chan_seen = saw_channel_n;
		end
		res_n.error_code = code;
		res_n.meta_kind  = meta_type_n;

		if (chunk_last) begin
			phase_n        = PH_DELTA;
			vlq_value_n    = '0;
			vlq_bytes_n    = '0;
			running_stat_n = ST_NONE;
			meta_type_n    = '0;
			remaining_n    = '0;
			saw_channel_n  = 1'b0;
			sticky_err_n   = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_DELTA;
			vlq_value_q    <= '0;
			vlq_bytes_q    <= '0;
			running_stat_q <= ST_NONE;
			meta_type_q    <= '0;
			remaining_q    <= '0;
			saw_channel_q  <= 1'b0;
			sticky_err_q   <= ERR_NONE;
		end else if (accept) begin
			phase_q        <= phase_n;
			vlq_value_q    <= vlq_value_n;
			vlq_bytes_q    <= vlq_bytes_n;
			running_stat_q <= running_stat_n;
			meta_type_q    <= meta_type_n;
			remaining_q    <= remaining_n;
			saw_channel_q  <= saw_channel_n;
			sticky_err_q   <= sticky_err_n;
		end
	end

	// output register with one skid word behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_load) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (accept)
				out_q <= res_n;
		end else if (accept) begin
			skid_q <= res_n;
		end
	end

	assign result_valid    = out_valid_q;
	assign byte_role       = out_q.byte_role;
	assign meta_kind       = out_q.meta_kind;
	assign text_valid      = out_q.text_valid;
	assign text_last       = out_q.text_last;
	assign error_code      = out_q.error_code;
	assign track_done      = out_q.track_done;
	assign track_ok        = out_q.track_ok;
	assign track_chan_seen = out_q.track_chan_seen;
	assign track_echo      = out_q.track_echo;

endmodule

// File: bench/tb_midi_track_event_parser.sv
`timescale 1ns / 1ps

module tb_midi_track_event_parser;

	import mtep_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_BYTES = 520;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 400000;

	class track_scoreboard;
		phase_t         parse_phase;
		vlq_t           vlq_acc;
		logic [2:0]     vlq_cnt;
		logic [7:0]     run_stat;
		logic [7:0]     cur_stat;
		logic [7:0]     meta_type;
		vlq_t           remaining;
		logic           saw_chan;
		err_t           sticky;
		result_t        expected_q[$];
		int unsigned    mismatches;

		function new();
			mismatches = 0;
			clear_state();
		endfunction

		function void clear_state();
			parse_phase = PH_DELTA;
			vlq_acc     = '0;
			vlq_cnt     = '0;
			run_stat    = ST_NONE;
			cur_stat    = '0;
			meta_type   = '0;
			remaining   = '0;
			saw_chan    = 1'b0;
			sticky      = ERR_NONE;
		endfunction

		// -1 too long, 0 more bytes follow, 1 quantity complete
		function int take_vlq(logic [7:0] b);
			vlq_acc = {vlq_acc[VLQ_W-8:0], b[6:0]};
			if (b[7]) begin
				if (int'(vlq_cnt) + 1 >= VLQ_MAX_BYTES)
					return -1;
				vlq_cnt = vlq_cnt + 3'd1;
				return 0;
			end
			vlq_cnt = '0;
			return 1;
		endfunction

		function vlq_t chan_len(logic [7:0] st);
			return (st[7:5] == ST_ONE_DATA_TOP) ? vlq_t'(1) : vlq_t'(2);
		endfunction

		function void note_byte(logic [7:0] b, logic last, logic [9:0] trk);
			result_t r;
			err_t    fail;
			int      vr;
			r = '0;
			r.byte_role = ROLE_ERROR;
			fail = ERR_NONE;
			if (sticky == ERR_NONE) begin
				case (parse_phase)
				PH_DELTA: begin
					r.byte_role = ROLE_DELTA;
					vr = take_vlq(b);
					if (vr < 0) begin
						fail = ERR_VLQ_LONG;
					end else if (vr > 0) begin
						vlq_acc = '0;
						parse_phase = PH_STATUS;
					end
				end
				PH_STATUS: begin
					r.byte_role = ROLE_STATUS;
					if (!b[7]) begin
						if (run_stat == ST_NONE) begin
							fail = ERR_NO_RUNNING;
						end else begin
							r.byte_role = ROLE_CHAN_DATA;
							cur_stat = run_stat;
							saw_chan = 1'b1;
							remaining = chan_len(cur_stat) - vlq_t'(1);
							parse_phase = (remaining != '0) ? PH_CHAN_DATA : PH_DELTA;
						end
					end else if (b == ST_META) begin
						run_stat = ST_NONE;
						cur_stat = b;
						parse_phase = PH_META_TYPE;
					end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
						run_stat = ST_NONE;
						cur_stat = b;
						parse_phase = PH_SYSEX_LEN;
					end else if (b[7:4] == 4'hF) begin
						fail = ERR_BAD_STATUS;
					end else begin
						cur_stat = b;
						run_stat = b;
						saw_chan = 1'b1;
						remaining = chan_len(b);
						parse_phase = PH_CHAN_DATA;
					end
				end
				PH_META_TYPE: begin
					r.byte_role = ROLE_META_TYPE;
					meta_type = b;
					parse_phase = PH_META_LEN;
				end
				PH_META_LEN, PH_SYSEX_LEN: begin
					r.byte_role = ROLE_LENGTH;
					vr = take_vlq(b);
					if (vr < 0) begin
						fail = ERR_VLQ_LONG;
					end else if (vr > 0) begin
						remaining = vlq_acc;
						vlq_acc = '0;
						if (remaining == '0)
							parse_phase = PH_DELTA;
						else
							parse_phase = (parse_phase == PH_META_LEN) ? PH_META_DATA
								: PH_SYSEX_DATA;
					end
				end
				PH_META_DATA, PH_SYSEX_DATA: begin
					if (parse_phase == PH_META_DATA && meta_type >= META_TEXT_LO
							&& meta_type <= META_TEXT_HI) begin
						r.byte_role = ROLE_TEXT;
						r.text_valid = 1'b1;
						r.text_last = (remaining == vlq_t'(1));
					end else begin
						r.byte_role = ROLE_SKIPPED;
					end
					remaining = remaining - vlq_t'(1);
					if (remaining == '0)
						parse_phase = PH_DELTA;
				end
				PH_CHAN_DATA: begin
					r.byte_role = ROLE_CHAN_DATA;
					remaining = remaining - vlq_t'(1);
					if (remaining == '0)
						parse_phase = PH_DELTA;
				end
				default: begin
					fail = ERR_BAD_STATUS;
				end
				endcase
				if (fail != ERR_NONE) begin
					sticky = fail;
					r.byte_role = ROLE_ERROR;
					parse_phase = PH_FAILED;
				end
			end
			r.error_code = sticky;
			r.meta_kind  = meta_type;
			r.track_echo = trk;
			if (last) begin
				// chunk ending mid-event counts as truncated unless already failed
				if (sticky == ERR_NONE && (parse_phase != PH_DELTA || vlq_cnt != '0))
					r.error_code = ERR_TRUNCATED;
				r.track_done = 1'b1;
				r.track_ok = (r.error_code == ERR_NONE);
				r.track_chan_seen = saw_chan;
				clear_state();
			end
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				$error("%s expected %0d got %0d", name, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				$error("result word with no byte pending");
				return;
			end
			want = expected_q.pop_front();
			compare_field("byte_role", want.byte_role, got.byte_role);
			compare_field("meta_kind", want.meta_kind, got.meta_kind);
			compare_field("text_valid", want.text_valid, got.text_valid);
			compare_field("text_last", want.text_last, got.text_last);
			compare_field("error_code", want.error_code, got.error_code);
			compare_field("track_done", want.track_done, got.track_done);
			compare_field("track_ok", want.track_ok, got.track_ok);
			compare_field("track_chan_seen", want.track_chan_seen,
				got.track_chan_seen);
			compare_field("track_echo", want.track_echo, got.track_echo);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  data_byte;
	logic        chunk_last;
	logic [9:0]  track_number;
	logic        result_valid;
	logic        result_stall;
	role_t       byte_role;
	logic [7:0]  meta_kind;
	logic        text_valid;
	logic        text_last;
	err_t        error_code;
	logic        track_done;
	logic        track_ok;
	logic        track_chan_seen;
	logic [9:0]  track_echo;

	track_scoreboard sb;
	logic [7:0]      chunk_bytes[$];
	logic [7:0]      gen_running;
	bit              gen_stop;
	bit              hold_req = 1'b0;
	int unsigned     burst_left = 0;
	int unsigned     bytes_sent = 0;
	int unsigned     cycle_count = 0;

	midi_track_event_parser dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.data_byte       (data_byte),
		.chunk_last      (chunk_last),
		.track_number    (track_number),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.byte_role       (byte_role),
		.meta_kind       (meta_kind),
		.text_valid      (text_valid),
		.text_last       (text_last),
		.error_code      (error_code),
		.track_done      (track_done),
		.track_ok        (track_ok),
		.track_chan_seen (track_chan_seen),
		.track_echo      (track_echo)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin : monitor
		result_t got;
		if (arst_n) begin
			if (byte_valid && !byte_stall)
				sb.note_byte(data_byte, chunk_last, track_number);
			if (result_valid && !result_stall) begin
				got.byte_role       = byte_role;
				got.meta_kind       = meta_kind;
				got.text_valid      = text_valid;
				got.text_last       = text_last;
				got.error_code      = error_code;
				got.track_done      = track_done;
				got.track_ok        = track_ok;
				got.track_chan_seen = track_chan_seen;
				got.track_echo      = track_echo;
				sb.check_result(got);
			end
		end
	end

	initial begin : receiver
		int unsigned mode;
		int unsigned left;
		result_stall = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// long hold-off so the skid fills and byte_stall must rise
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(5, 60);
			end
			left--;
			case (mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 9) < 7);
			default: result_stall <= (left % 3 == 0);
			endcase
		end
	end

	// entered and left at a falling edge
	task automatic push_byte(logic [7:0] b, logic last, logic [9:0] trk);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		byte_valid   <= 1'b1;
		data_byte    <= b;
		chunk_last   <= last;
		track_number <= trk;
		// hold the word until the parser takes it
		do @(posedge clk); while (byte_stall);
		@(negedge clk);
	endtask

	task automatic send_chunk(logic [9:0] trk);
		int i;
		for (i = 0; i < chunk_bytes.size(); i++) begin
			push_byte(chunk_bytes[i], i == chunk_bytes.size() - 1, trk);
			bytes_sent++;
		end
	endtask

	// nbytes groups of seven bits, leading groups may be zero
	task automatic emit_vlq(int unsigned value, int nbytes);
		int k;
		logic [7:0] b;
		for (k = nbytes - 1; k >= 0; k--) begin
			b = 8'((value >> (7 * k)) & 32'h7F);
			if (k != 0)
				b[7] = 1'b1;
			chunk_bytes.push_back(b);
		end
	endtask

	task automatic emit_delta();
		int nb;
		if ($urandom_range(0, 49) == 0)
			nb = 5;
		else if ($urandom_range(0, 3) == 0)
			nb = $urandom_range(2, 4);
		else
			nb = 1;
		emit_vlq($urandom, nb);
	endtask

	task automatic emit_chan_data(logic [7:0] st, bit running);
		int n;
		int i;
		logic [7:0] b;
		n = (st[7:5] == ST_ONE_DATA_TOP) ? 1 : 2;
		for (i = 0; i < n; i++) begin
			b = 8'($urandom_range(0, 8'h7F));
			// under running status the first data byte sits where a status would
			if (!(running && i == 0) && $urandom_range(0, 19) == 0)
				b = 8'($urandom);
			chunk_bytes.push_back(b);
		end
	endtask

	task automatic emit_payload_event(logic [7:0] lead, logic [7:0] kind, bit with_kind);
		int unsigned n;
		int i;
		chunk_bytes.push_back(lead);
		if (with_kind)
			chunk_bytes.push_back(kind);
		gen_running = ST_NONE;
		if ($urandom_range(0, 19) == 0) begin
			// length far beyond the chunk, which then ends early
			emit_vlq($urandom | 32'h0020_0000, 4);
			repeat ($urandom_range(0, 3)) chunk_bytes.push_back(8'($urandom));
			gen_stop = 1'b1;
		end else begin
			n = $urandom_range(0, 6);
			emit_vlq(n, ($urandom_range(0, 29) == 0) ? 5 : $urandom_range(1, 2));
			for (i = 0; i < n; i++)
				chunk_bytes.push_back(8'($urandom));
		end
	endtask

	task automatic emit_event();
		int unsigned sel;
		logic [7:0] st;
		sel = $urandom_range(0, 99);
		if (sel >= 40 && sel < 60 && gen_running == ST_NONE)
			sel = 0;
		if (sel < 40) begin
			st = 8'($urandom_range(8'h80, 8'hEF));
			chunk_bytes.push_back(st);
			gen_running = st;
			emit_chan_data(st, 1'b0);
		end else if (sel < 60) begin
			emit_chan_data(gen_running, 1'b1);
		end else if (sel < 80) begin
			st = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(META_TEXT_LO, META_TEXT_HI))
				: 8'($urandom);
			emit_payload_event(ST_META, st, 1'b1);
		end else if (sel < 92) begin
			emit_payload_event(($urandom_range(0, 1) == 0) ? ST_SYSEX : ST_SYSEX_ESC,
				8'h00, 1'b0);
		end else begin
			chunk_bytes.push_back(8'($urandom));
		end
	endtask

	task automatic build_chunk();
		int unsigned nev;
		int unsigned cut;
		int unsigned i;
		chunk_bytes.delete();
		gen_running = ST_NONE;
		gen_stop = 1'b0;
		if ($urandom_range(0, 11) == 0) begin
			repeat ($urandom_range(1, 12)) chunk_bytes.push_back(8'($urandom));
			return;
		end
		nev = $urandom_range(1, 6);
		for (i = 0; i < nev && !gen_stop; i++) begin
			emit_delta();
			emit_event();
		end
		if ($urandom_range(0, 4) == 0) begin
			cut = $urandom_range(1, chunk_bytes.size());
			while (chunk_bytes.size() > cut)
				void'(chunk_bytes.pop_back());
		end
	endtask

	initial begin : stimulus
		logic [9:0] trk;
		sb = new();
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		data_byte    = '0;
		chunk_last   = 1'b0;
		track_number = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// lone delta byte: truncated
		chunk_bytes = '{8'h00};
		send_chunk(10'd0);
		// text meta, zero-length escape sysex, channel with high data bit,
		// one-data-byte program change, then running status
		chunk_bytes = '{8'h00, ST_META, 8'h03, 8'h02, 8'h41, 8'h42,
			8'h00, ST_SYSEX_ESC, 8'h00,
			8'h00, 8'h90, 8'hBC, 8'h7F,
			8'h00, 8'hC0, 8'h05,
			8'h00, 8'h05};
		send_chunk(10'd1023);
		// delta of too many bytes, then a byte after the error
		chunk_bytes = '{8'h81, 8'hFF, 8'h80, 8'h81, 8'h00};
		send_chunk(10'd512);
		// data byte with no running status
		chunk_bytes = '{8'h00, 8'h40};
		send_chunk(10'd1);
		// system status other than sysex or meta
		chunk_bytes = '{8'h00, 8'hF1};
		send_chunk(10'd2);

		hold_req = 1'b1;
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			build_chunk();
			if ($urandom_range(0, 9) == 0)
				trk = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1023;
			else
				trk = 10'($urandom_range(0, 1023));
			send_chunk(trk);
		end
		byte_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
